// ===== hw/rtl/sbss_pkg.sv =====
// ----------------------------------------------------------------------------
// sbss_pkg
// Shared types, codes and helpers of the sensorless BLDC startup sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbss_pkg;

	localparam int unsigned PERIOD_SHIFT   = 3;
	localparam int unsigned PERIOD_DIVISOR = 1 << PERIOD_SHIFT;

	localparam logic [15:0] PERIOD_STEP = 16'd100;
	localparam logic [15:0] DUTY_STEP   = 16'd200;
	localparam logic [7:0]  PWM_TOP     = 8'd255;
	localparam logic [2:0]  LAST_STEP   = 3'd5;

	localparam logic [15:0] START_PERIOD_RST = 16'd20000;
	localparam logic [15:0] START_DUTY_RST   = 16'd2560;
	localparam logic [15:0] END_PERIOD_RST   = 16'd6000;
	localparam logic [15:0] END_DUTY_RST     = 16'd5120;
	localparam logic [15:0] ALIGN_PERIOD_RST = 16'd34464;

	typedef enum logic [2:0] {
		CMD_TIMER     = 3'd0,
		CMD_ZERO_CROSS = 3'd1,
		CMD_START     = 3'd2,
		CMD_STOP      = 3'd3,
		CMD_END_UP    = 3'd4,
		CMD_END_DOWN  = 3'd5,
		CMD_END_RESET = 3'd6,
		CMD_NOP       = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_OFF       = 3'd0,
		MODE_ALIGN     = 3'd1,
		MODE_RAMP_A    = 3'd2,
		MODE_RAMP_B    = 3'd3,
		MODE_FREEWHEEL = 3'd4,
		MODE_CLOSED_A  = 3'd5,
		MODE_CLOSED_B  = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		REG_START_PERIOD = 3'd0,
		REG_START_DUTY   = 3'd1,
		REG_END_PERIOD   = 3'd2,
		REG_END_DUTY     = 3'd3,
		REG_ALIGN_PERIOD = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] start_period;
		logic [15:0] start_duty;
		logic [15:0] end_period_default;
		logic [15:0] end_duty;
		logic [15:0] align_period;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  run_state;
		logic [2:0]  step;
		logic [2:0]  high_mask;
		logic [2:0]  low_mask;
		logic [1:0]  sense_channel;
		logic        sense_rising;
		logic [15:0] timer_reload;
		logic        timer_restart;
		logic        timer_running;
		logic [7:0]  pwm_compare;
		logic        sense_clear;
	} result_t;

	typedef struct packed {
		logic [2:0] high;
		logic [2:0] low;
		logic [1:0] chan;
		logic       rising;
	} drive_t;

	// six-step commutation table
	function automatic drive_t step_drive(input logic [2:0] s);
		drive_t d;
		d.rising = ~s[0];
		unique case (s)
			3'd1: begin d.high = 3'd2; d.low = 3'd4; d.chan = 2'd0; end
			3'd2: begin d.high = 3'd2; d.low = 3'd1; d.chan = 2'd2; end
			3'd3: begin d.high = 3'd4; d.low = 3'd1; d.chan = 2'd1; end
			3'd4: begin d.high = 3'd4; d.low = 3'd2; d.chan = 2'd0; end
			3'd5: begin d.high = 3'd1; d.low = 3'd2; d.chan = 2'd2; end
			default: begin d.high = 3'd1; d.low = 3'd4; d.chan = 2'd1; d.rising = 1'b1; end
		endcase
		return d;
	endfunction

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
		return (a >= b) ? (a - b) : 16'd0;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sbss_req_if.sv =====
// ----------------------------------------------------------------------------
// sbss_req_if
// Request channel: event command and timer count.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbss_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [15:0] timer_count;

	modport source (output valid, output command, output timer_count, input ready);
	modport sink (input valid, input command, input timer_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbss_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sbss_rsp_if
// Result channel: drive, sense, timer and pwm status after each event.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbss_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  run_state;
	logic [2:0]  step;
	logic [2:0]  high_mask;
	logic [2:0]  low_mask;
	logic [1:0]  sense_channel;
	logic        sense_rising;
	logic [15:0] timer_reload;
	logic        timer_restart;
	logic        timer_running;
	logic [7:0]  pwm_compare;
	logic        sense_clear;

	modport source (output valid, output run_state, output step, output high_mask,
		output low_mask, output sense_channel, output sense_rising, output timer_reload,
		output timer_restart, output timer_running, output pwm_compare,
		output sense_clear, input ready);
	modport sink (input valid, input run_state, input step, input high_mask,
		input low_mask, input sense_channel, input sense_rising, input timer_reload,
		input timer_restart, input timer_running, input pwm_compare,
		input sense_clear, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbss_cfg.sv =====
// ----------------------------------------------------------------------------
// sbss_cfg
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
`default_nettype none

module sbss_cfg
	import sbss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        we,
	input  wire logic [2:0]  index,
	input  wire logic [15:0] wdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_period       <= START_PERIOD_RST;
			cfg_q.start_duty         <= START_DUTY_RST;
			cfg_q.end_period_default <= END_PERIOD_RST;
			cfg_q.end_duty           <= END_DUTY_RST;
			cfg_q.align_period       <= ALIGN_PERIOD_RST;
		end else if (we) begin
			case (reg_idx_t'(index))
				REG_START_PERIOD: cfg_q.start_period       <= wdata;
				REG_START_DUTY:   cfg_q.start_duty         <= wdata;
				REG_END_PERIOD:   cfg_q.end_period_default <= wdata;
				REG_END_DUTY:     cfg_q.end_duty           <= wdata;
				REG_ALIGN_PERIOD: cfg_q.align_period       <= wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sbss_engine.sv =====
// ----------------------------------------------------------------------------
// sbss_engine
// Sequencer state and single-pass event logic; result is the new status.
// ----------------------------------------------------------------------------
`default_nettype none

module sbss_engine
	import sbss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic [2:0]  command,
	input  wire logic [15:0] timer_count,
	input  wire cfg_t        cfg,
	output result_t          result
);

	mode_t       mode_q, mode_d;
	logic [2:0]  step_q, step_d;
	logic [15:0] ramp_period_q, ramp_period_d;
	logic [15:0] ramp_duty_q, ramp_duty_d;
	logic [15:0] end_period_q, end_period_d;
	logic [15:0] avg_q, avg_d;
	logic [2:0]  high_q, high_d;
	logic [2:0]  low_q, low_d;
	logic [1:0]  chan_q, chan_d;
	logic        rising_q, rising_d;
	logic [15:0] reload_q, reload_d;
	logic        running_q, running_d;
	logic [7:0]  pwm_q, pwm_d;
	logic        restart, clr;

	logic [2:0]  step_next;
	drive_t      drv_zero, drv_next;
	logic [15:0] period_div;
	logic [19:0] period_x10;
	logic [17:0] avg_sum;
	logic [15:0] avg_new;
	logic [7:0]  duty_cmp;

	assign step_next  = (step_q >= LAST_STEP) ? 3'd0 : step_q + 3'd1;
	assign drv_zero   = step_drive(3'd0);
	assign drv_next   = step_drive(step_next);
	assign period_div = ramp_period_q >> PERIOD_SHIFT;
	assign period_x10 = {1'b0, ramp_period_q, 3'b000} + {3'b000, ramp_period_q, 1'b0};
	assign avg_sum    = {1'b0, avg_q, 1'b0} + {2'b00, avg_q} + {2'b00, timer_count};
	assign avg_new    = avg_sum[17:2];
	assign duty_cmp   = PWM_TOP - ramp_duty_q[15:8];

	always_comb begin
		mode_d        = mode_q;
		step_d        = step_q;
		ramp_period_d = ramp_period_q;
		ramp_duty_d   = ramp_duty_q;
		end_period_d  = end_period_q;
		avg_d         = avg_q;
		high_d        = high_q;
		low_d         = low_q;
		chan_d        = chan_q;
		rising_d      = rising_q;
		reload_d      = reload_q;
		running_d     = running_q;
		pwm_d         = pwm_q;
		restart       = 1'b0;
		clr           = 1'b0;
		unique case (cmd_t'(command))
			CMD_TIMER: begin
				case (mode_q)
					MODE_ALIGN: begin
						step_d   = 3'd0;
						high_d   = drv_zero.high;
						low_d    = drv_zero.low;
						chan_d   = drv_zero.chan;
						rising_d = drv_zero.rising;
						restart  = 1'b1;
						reload_d = cfg.align_period;
						pwm_d    = duty_cmp;
						mode_d   = MODE_RAMP_A;
					end
					MODE_RAMP_A: begin
						step_d   = step_next;
						high_d   = drv_next.high;
						low_d    = drv_next.low;
						chan_d   = drv_next.chan;
						rising_d = drv_next.rising;
						restart  = 1'b1;
						reload_d = period_div;
						pwm_d    = duty_cmp;
						mode_d   = MODE_RAMP_B;
					end
					MODE_RAMP_B: begin
						restart  = 1'b1;
						reload_d = ramp_period_q - period_div;
						if (ramp_period_q > end_period_q) begin
							ramp_period_d = sat_sub(ramp_period_q, PERIOD_STEP);
							if (ramp_duty_q < cfg.end_duty)
								ramp_duty_d = sat_add(ramp_duty_q, DUTY_STEP);
							mode_d = MODE_RAMP_A;
						end else begin
							clr    = 1'b1;
							mode_d = MODE_FREEWHEEL;
						end
					end
					MODE_FREEWHEEL: high_d = 3'd0;
					MODE_CLOSED_A: begin
						restart  = 1'b1;
						reload_d = (period_x10[19:16] != 4'd0) ? 16'hFFFF : period_x10[15:0];
						mode_d   = MODE_CLOSED_B;
						clr      = 1'b1;
					end
					MODE_CLOSED_B: begin
						high_d    = 3'd0;
						low_d     = 3'd0;
						running_d = 1'b0;
						mode_d    = MODE_OFF;
					end
					default: begin
					end
				endcase
			end
			CMD_ZERO_CROSS: begin
				if (mode_q == MODE_FREEWHEEL || mode_q == MODE_CLOSED_B) begin
					step_d   = step_next;
					high_d   = drv_next.high;
					low_d    = drv_next.low;
					chan_d   = drv_next.chan;
					rising_d = drv_next.rising;
					avg_d    = avg_new;
					restart  = 1'b1;
					reload_d = avg_new >> PERIOD_SHIFT;
					mode_d   = MODE_CLOSED_A;
				end
			end
			CMD_START: begin
				ramp_period_d = cfg.start_period;
				ramp_duty_d   = cfg.start_duty;
				restart       = 1'b1;
				reload_d      = cfg.align_period;
				running_d     = 1'b1;
				mode_d        = MODE_ALIGN;
			end
			CMD_STOP: begin
				high_d    = 3'd0;
				low_d     = 3'd0;
				running_d = 1'b0;
				mode_d    = MODE_OFF;
			end
			CMD_END_UP:    end_period_d = sat_add(end_period_q, PERIOD_STEP);
			CMD_END_DOWN:  end_period_d = sat_sub(end_period_q, PERIOD_STEP);
			CMD_END_RESET: end_period_d = cfg.end_period_default;
			CMD_NOP: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_OFF;
			step_q        <= 3'd0;
			ramp_period_q <= START_PERIOD_RST;
			ramp_duty_q   <= START_DUTY_RST;
			end_period_q  <= END_PERIOD_RST;
			avg_q         <= 16'd0;
			high_q        <= 3'd0;
			low_q         <= 3'd0;
			chan_q        <= 2'd0;
			rising_q      <= 1'b0;
			reload_q      <= 16'd0;
			running_q     <= 1'b0;
			pwm_q         <= PWM_TOP;
		end else if (en) begin
			mode_q        <= mode_d;
			step_q        <= step_d;
			ramp_period_q <= ramp_period_d;
			ramp_duty_q   <= ramp_duty_d;
			end_period_q  <= end_period_d;
			avg_q         <= avg_d;
			high_q        <= high_d;
			low_q         <= low_d;
			chan_q        <= chan_d;
			rising_q      <= rising_d;
			reload_q      <= reload_d;
			running_q     <= running_d;
			pwm_q         <= pwm_d;
		end
	end

	always_comb begin
		result.run_state     = mode_d;
		result.step          = step_d;
		result.high_mask     = high_d;
		result.low_mask      = low_d;
		result.sense_channel = chan_d;
		result.sense_rising  = rising_d;
		result.timer_reload  = reload_d;
		result.timer_restart = restart;
		result.timer_running = running_d;
		result.pwm_compare   = pwm_d;
		result.sense_clear   = clr;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sensorless_bldc_startup_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// sensorless_bldc_startup_sequencer_core
// Six-step sensorless BLDC startup sequencer: align, open-loop ramp,
// freewheel and zero-cross driven closed loop.
// ----------------------------------------------------------------------------
// Takes one event request per clock while the result side is not stalled, and
// returns one status result per request: each is held in the request register,
// then passes through the single-pass step logic into the result register. The
// result register lets a new request enter while the previous result waits.
// The commutation period divisor is a power of two (package constant).
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module sensorless_bldc_startup_sequencer_core
	import sbss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	sbss_req_if.sink         req,
	sbss_rsp_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	cfg_t        cfg;
	result_t     result;
	logic        valid_s1;
	logic [2:0]  command_s1;
	logic [15:0] count_s1;
	logic        valid_s2;
	result_t     result_s2;
	logic        adv;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			command_s1 <= req.command;
			count_s1   <= req.timer_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			result_s2 <= result;
	end

	sbss_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	sbss_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.command     (command_s1),
		.timer_count (count_s1),
		.cfg         (cfg),
		.result      (result)
	);

	assign rsp.valid         = valid_s2;
	assign rsp.run_state     = result_s2.run_state;
	assign rsp.step          = result_s2.step;
	assign rsp.high_mask     = result_s2.high_mask;
	assign rsp.low_mask      = result_s2.low_mask;
	assign rsp.sense_channel = result_s2.sense_channel;
	assign rsp.sense_rising  = result_s2.sense_rising;
	assign rsp.timer_reload  = result_s2.timer_reload;
	assign rsp.timer_restart = result_s2.timer_restart;
	assign rsp.timer_running = result_s2.timer_running;
	assign rsp.pwm_compare   = result_s2.pwm_compare;
	assign rsp.sense_clear   = result_s2.sense_clear;

endmodule

`default_nettype wire

// ===== hw/rtl/sbss_chk.sv =====
// ----------------------------------------------------------------------------
// sbss_chk
// Port-level checks of the startup sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbss_chk
	import sbss_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [2:0]  run_state,
	input wire logic [2:0]  step,
	input wire logic [15:0] timer_reload,
	input wire logic        timer_restart,
	input wire logic        timer_running,
	input wire logic        sense_clear
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(run_state) && $stable(step)
			&& $stable(timer_reload))
		else $error("stalled result changed");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> step <= LAST_STEP)
		else $error("step out of range");

	a_off_timer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((run_state == MODE_OFF) == !timer_running))
		else $error("timer state disagrees with run state");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && timer_restart |-> run_state != MODE_OFF)
		else $error("timer restart while off");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && sense_clear |-> run_state == MODE_FREEWHEEL || run_state == MODE_CLOSED_B)
		else $error("comparator clear in wrong state");

endmodule

bind sensorless_bldc_startup_sequencer_core sbss_chk u_sbss_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.run_state     (rsp.run_state),
	.step          (rsp.step),
	.timer_reload  (rsp.timer_reload),
	.timer_restart (rsp.timer_restart),
	.timer_running (rsp.timer_running),
	.sense_clear   (rsp.sense_clear)
);

`default_nettype wire

// ===== tb/sv/tb_sensorless_bldc_startup_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensorless_bldc_startup_sequencer_core
// Self-checking bench for the six-step startup sequencer core.
// ----------------------------------------------------------------------------
// A scoreboard object predicts the status after every accepted request
// and compares each returned status field by field, in order. A short
// directed part walks every command through align, ramp, freewheel and
// the closed loop. Random phases follow, each under its own register
// setting. Commands are picked to follow the run state, so most ramps
// finish and the closed loop is reached. Both channels stall at random.
// One stretch has no stalls at all, and one long result hold-off lets
// the core back up onto its request channel.
// ----------------------------------------------------------------------------

module tb_sensorless_bldc_startup_sequencer_core;
	import sbss_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned PHASES        = 12;
	localparam int unsigned PHASE_ITEMS   = 100;
	localparam int unsigned CALM_PHASE    = 6;
	localparam int unsigned HOLD_AT       = 400;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned IDLE_PERCENT  = 28;
	localparam int unsigned REPORT_MAX    = 10;

	class startup_scoreboard;
		cfg_t        cfg;
		mode_t       mode;
		logic [2:0]  pos;
		logic [15:0] ramp_period;
		logic [15:0] ramp_duty;
		logic [15:0] end_period;
		logic [15:0] avg_period;
		logic [15:0] reload;
		logic [2:0]  high_on;
		logic [2:0]  low_on;
		logic [1:0]  chan;
		logic        rising;
		logic        running;
		logic [7:0]  pwm;
		result_t     status_q[$];
		int unsigned mismatches;

		function new();
			cfg = '{START_PERIOD_RST, START_DUTY_RST, END_PERIOD_RST, END_DUTY_RST,
				ALIGN_PERIOD_RST};
			mode = MODE_OFF;
			pos = 3'd0;
			ramp_period = START_PERIOD_RST;
			ramp_duty = START_DUTY_RST;
			end_period = END_PERIOD_RST;
			avg_period = 16'd0;
			reload = 16'd0;
			high_on = 3'd0;
			low_on = 3'd0;
			chan = 2'd0;
			rising = 1'b0;
			running = 1'b0;
			pwm = 8'd255;
			mismatches = 0;
		endfunction

		function void load_drive();
			rising = ~pos[0];
			case (pos)
				3'd1: begin high_on = 3'd2; low_on = 3'd4; chan = 2'd0; end
				3'd2: begin high_on = 3'd2; low_on = 3'd1; chan = 2'd2; end
				3'd3: begin high_on = 3'd4; low_on = 3'd1; chan = 2'd1; end
				3'd4: begin high_on = 3'd4; low_on = 3'd2; chan = 2'd0; end
				3'd5: begin high_on = 3'd1; low_on = 3'd2; chan = 2'd2; end
				default: begin high_on = 3'd1; low_on = 3'd4; chan = 2'd1; rising = 1'b1; end
			endcase
		endfunction

		function void advance();
			pos = (pos >= 3'd5) ? 3'd0 : pos + 3'd1;
			load_drive();
		endfunction

		function void halt();
			high_on = 3'd0;
			low_on = 3'd0;
			running = 1'b0;
			mode = MODE_OFF;
		endfunction

		function void note_request(cmd_t cmd, logic [15:0] cnt);
			result_t     r;
			logic        restart;
			logic        clr;
			logic [16:0] wide;
			int unsigned acc;
			restart = 1'b0;
			clr = 1'b0;
			case (cmd)
				CMD_TIMER: begin
					case (mode)
						MODE_ALIGN: begin
							pos = 3'd0;
							restart = 1'b1;
							reload = cfg.align_period;
							pwm = 8'd255 - ramp_duty[15:8];
							load_drive();
							mode = MODE_RAMP_A;
						end
						MODE_RAMP_A: begin
							advance();
							restart = 1'b1;
							reload = ramp_period / PERIOD_DIVISOR;
							pwm = 8'd255 - ramp_duty[15:8];
							mode = MODE_RAMP_B;
						end
						MODE_RAMP_B: begin
							restart = 1'b1;
							reload = ramp_period - ramp_period / PERIOD_DIVISOR;
							if (ramp_period > end_period) begin
								ramp_period = (ramp_period >= 16'd100) ? ramp_period - 16'd100 : 16'd0;
								if (ramp_duty < cfg.end_duty) begin
									wide = {1'b0, ramp_duty} + 17'd200;
									ramp_duty = wide[16] ? 16'hFFFF : wide[15:0];
								end
								mode = MODE_RAMP_A;
							end else begin
								clr = 1'b1;
								mode = MODE_FREEWHEEL;
							end
						end
						MODE_FREEWHEEL: begin
							high_on = 3'd0;
						end
						MODE_CLOSED_A: begin
							restart = 1'b1;
							acc = 32'd10 * ramp_period;
							reload = (acc > 32'd65535) ? 16'hFFFF : acc[15:0];
							mode = MODE_CLOSED_B;
							clr = 1'b1;
						end
						MODE_CLOSED_B: begin
							halt();
						end
						default: begin
						end
					endcase
				end
				CMD_ZERO_CROSS: begin
					if (mode == MODE_FREEWHEEL || mode == MODE_CLOSED_B) begin
						advance();
						acc = (32'd3 * avg_period + cnt) / 32'd4;
						avg_period = acc[15:0];
						restart = 1'b1;
						reload = avg_period / PERIOD_DIVISOR;
						mode = MODE_CLOSED_A;
					end
				end
				CMD_START: begin
					ramp_period = cfg.start_period;
					ramp_duty = cfg.start_duty;
					restart = 1'b1;
					reload = cfg.align_period;
					running = 1'b1;
					mode = MODE_ALIGN;
				end
				CMD_STOP: begin
					halt();
				end
				CMD_END_UP: begin
					wide = {1'b0, end_period} + 17'd100;
					end_period = wide[16] ? 16'hFFFF : wide[15:0];
				end
				CMD_END_DOWN: begin
					end_period = (end_period >= 16'd100) ? end_period - 16'd100 : 16'd0;
				end
				CMD_END_RESET: begin
					end_period = cfg.end_period_default;
				end
				default: begin
				end
			endcase
			r.run_state = mode;
			r.step = pos;
			r.high_mask = high_on;
			r.low_mask = low_on;
			r.sense_channel = chan;
			r.sense_rising = rising;
			r.timer_reload = reload;
			r.timer_restart = restart;
			r.timer_running = running;
			r.pwm_compare = pwm;
			r.sense_clear = clr;
			status_q.push_back(r);
		endfunction

		function int unsigned pending();
			return status_q.size();
		endfunction

		function void report(string field, logic [15:0] want, logic [15:0] got);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("mismatch %s: expected %0d, got %0d", field, want, got);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch: result with no request waiting");
				return;
			end
			want = status_q.pop_front();
			if (got.run_state !== want.run_state)
				report("run_state", want.run_state, got.run_state);
			if (got.step !== want.step)
				report("step", want.step, got.step);
			if (got.high_mask !== want.high_mask)
				report("high_mask", want.high_mask, got.high_mask);
			if (got.low_mask !== want.low_mask)
				report("low_mask", want.low_mask, got.low_mask);
			if (got.sense_channel !== want.sense_channel)
				report("sense_channel", want.sense_channel, got.sense_channel);
			if (got.sense_rising !== want.sense_rising)
				report("sense_rising", want.sense_rising, got.sense_rising);
			if (got.timer_reload !== want.timer_reload)
				report("timer_reload", want.timer_reload, got.timer_reload);
			if (got.timer_restart !== want.timer_restart)
				report("timer_restart", want.timer_restart, got.timer_restart);
			if (got.timer_running !== want.timer_running)
				report("timer_running", want.timer_running, got.timer_running);
			if (got.pwm_compare !== want.pwm_compare)
				report("pwm_compare", want.pwm_compare, got.pwm_compare);
			if (got.sense_clear !== want.sense_clear)
				report("sense_clear", want.sense_clear, got.sense_clear);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_wdata;

	sbss_req_if req_ch();
	sbss_rsp_if rsp_ch();

	sensorless_bldc_startup_sequencer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	startup_scoreboard sb;
	logic              calm;
	int unsigned       results_seen = 0;
	int unsigned       hold_left = 0;
	int unsigned       cycle_count;
	result_t           seen_status;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, one long hold-off
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen_status = {rsp_ch.run_state, rsp_ch.step, rsp_ch.high_mask, rsp_ch.low_mask,
				rsp_ch.sense_channel, rsp_ch.sense_rising, rsp_ch.timer_reload,
				rsp_ch.timer_restart, rsp_ch.timer_running, rsp_ch.pwm_compare,
				rsp_ch.sense_clear};
			sb.check_result(seen_status);
			results_seen++;
			if (results_seen == HOLD_AT)
				hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_request(cmd_t cmd, logic [15:0] cnt);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.timer_count <= cnt;
		sb.note_request(cmd, cnt);
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic write_settings(cfg_t c);
		write_register(REG_START_PERIOD, c.start_period);
		write_register(REG_START_DUTY, c.start_duty);
		write_register(REG_END_PERIOD, c.end_period_default);
		write_register(REG_END_DUTY, c.end_duty);
		write_register(REG_ALIGN_PERIOD, c.align_period);
		cfg_we <= 1'b0;
		sb.cfg = c;
	endtask

	// mostly the command that moves the current state on, some noise
	function automatic cmd_t pick_command(mode_t m);
		int unsigned roll;
		cmd_t        noise;
		roll = $urandom_range(0, 99);
		noise = cmd_t'($urandom_range(0, 7));
		case (m)
			MODE_OFF:
				return (roll < 70) ? CMD_START : noise;
			MODE_ALIGN, MODE_RAMP_A, MODE_RAMP_B:
				return (roll < 90) ? CMD_TIMER : noise;
			MODE_FREEWHEEL:
				return (roll < 50) ? CMD_ZERO_CROSS : (roll < 80) ? CMD_TIMER : noise;
			MODE_CLOSED_A:
				return (roll < 70) ? CMD_TIMER : (roll < 85) ? CMD_ZERO_CROSS : noise;
			default:
				return (roll < 65) ? CMD_ZERO_CROSS : (roll < 85) ? CMD_TIMER : noise;
		endcase
	endfunction

	function automatic cfg_t phase_settings(int unsigned phase);
		cfg_t        c;
		int unsigned top;
		case (phase)
			0: c = '{START_PERIOD_RST, START_DUTY_RST, END_PERIOD_RST, END_DUTY_RST,
				ALIGN_PERIOD_RST};
			1: c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
			2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
			3: c = '{16'd50, 16'd65500, 16'd0, 16'hFFFF, 16'($urandom_range(0, 65535))};
			default: begin
				c.end_period_default = 16'($urandom_range(0, 65535));
				top = c.end_period_default + $urandom_range(0, 1500);
				c.start_period = (top > 65535) ? 16'hFFFF : top[15:0];
				c.start_duty = 16'($urandom_range(0, 65535));
				c.end_duty = 16'($urandom_range(0, 65535));
				c.align_period = 16'($urandom_range(0, 65535));
			end
		endcase
		return c;
	endfunction

	initial begin
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START_PERIOD;
		cfg_wdata = 16'd0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_TIMER;
		req_ch.timer_count = 16'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_settings(phase_settings(0));

		// idle-state events, end adjust, start, restart while running, stop
		send_request(CMD_TIMER, 16'hFFFF);
		send_request(CMD_ZERO_CROSS, 16'h1234);
		send_request(CMD_NOP, 16'd0);
		send_request(CMD_END_UP, 16'd0);
		send_request(CMD_END_DOWN, 16'd0);
		send_request(CMD_END_RESET, 16'd0);
		send_request(CMD_START, 16'd0);
		send_request(CMD_TIMER, 16'd0);
		send_request(CMD_TIMER, 16'd0);
		send_request(CMD_START, 16'd0);
		send_request(CMD_STOP, 16'd0);
		drain();

		// one-pass ramp with duty saturation, then freewheel and closed loop
		write_settings('{16'd6100, 16'd65500, END_PERIOD_RST, 16'hFFFF, 16'd1000});
		send_request(CMD_START, 16'd0);
		repeat (6)
			send_request(CMD_TIMER, 16'd0);
		send_request(CMD_ZERO_CROSS, 16'hFFFF);
		send_request(CMD_TIMER, 16'd0);
		send_request(CMD_ZERO_CROSS, 16'd0);
		send_request(CMD_TIMER, 16'd0);
		send_request(CMD_TIMER, 16'd0);
		drain();

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			write_settings(phase_settings(phase));
			calm = (phase == CALM_PHASE);
			send_request(CMD_END_RESET, 16'($urandom_range(0, 65535)));
			for (int unsigned n = 0; n < PHASE_ITEMS; n++)
				send_request(pick_command(sb.mode), 16'($urandom_range(0, 65535)));
			drain();
			calm = 1'b0;
		end

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
